// ===== sv/mws2d_pkg.sv =====
// ----------------------------------------------------------------------------
// mws2d_pkg: shared types and constants of max_window_sum_2d
// element and result widths, register indexes, default capacities and the
// per-beat control flags that travel down the pipeline
// ----------------------------------------------------------------------------
package mws2d_pkg;

    // default capacities
    localparam int DEF_MAX_COLS     = 1024;
    localparam int DEF_MAX_WIN_ROWS = 64;
    localparam int DEF_MAX_WIN_COLS = 64;

    // fixed field widths
    localparam int ELEM_W     = 16;
    localparam int BEST_W     = 27;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int ROWS_W     = 16;
    localparam int COLS_W     = 11;
    localparam int WIN_W      = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 2'd3;

    // per-beat control flags, worked out from the raster position
    typedef struct packed {
        logic win_ok;   // window fits matrix and capacity
        logic c_first;  // first column of a row
        logic c_sub;    // an element leaves the horizontal window
        logic c_full;   // horizontal window is full
        logic r_sub;    // a row of sums leaves the vertical window
        logic r_full;   // vertical window is full
        logic r_zero;   // first row of the frame
        logic last;     // last element of the frame
    } t_ctl;

endpackage

// ===== sv/mws2d_rowsum.sv =====
// ----------------------------------------------------------------------------
// mws2d_rowsum: horizontal window sum
// keeps the last elements of the current row in a small memory and, while enabled,
// updates the running sum of the row window one beat per cycle
// ----------------------------------------------------------------------------
module mws2d_rowsum #(
    parameter int MAX_COLS     = mws2d_pkg::DEF_MAX_COLS,
    parameter int MAX_WIN_ROWS = mws2d_pkg::DEF_MAX_WIN_ROWS,
    parameter int MAX_WIN_COLS = mws2d_pkg::DEF_MAX_WIN_COLS,
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int CSL_W = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1,
    localparam int HA_W  = (MAX_WIN_ROWS * MAX_COLS > 1) ? $clog2(MAX_WIN_ROWS * MAX_COLS) : 1,
    localparam int RUN_W = mws2d_pkg::ELEM_W + $clog2(MAX_WIN_COLS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [mws2d_pkg::ELEM_W-1:0] i_elem,
    input  logic        [CSL_W-1:0]            i_slot,
    input  mws2d_pkg::t_ctl                    i_ctl,
    input  logic        [COL_W-1:0]            i_col,
    input  logic        [HA_W-1:0]             i_hslot,
    output logic                               o_valid,
    output mws2d_pkg::t_ctl                    o_ctl,
    output logic        [COL_W-1:0]            o_col,
    output logic        [HA_W-1:0]             o_hslot,
    output logic signed [RUN_W-1:0]            o_run
);

    logic signed [mws2d_pkg::ELEM_W-1:0] row_delay [MAX_WIN_COLS];

    logic                                r_valid;
    mws2d_pkg::t_ctl                     r_ctl;
    logic        [COL_W-1:0]             r_col;
    logic        [HA_W-1:0]              r_hslot;
    logic signed [mws2d_pkg::ELEM_W-1:0] r_elem;
    logic signed [mws2d_pkg::ELEM_W-1:0] r_old;
    logic signed [RUN_W-1:0]             r_run;
    logic signed [RUN_W-1:0]             run_base;
    logic signed [RUN_W-1:0]             run_drop;

    // read before write: the slot still holds the element one window back
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_old <= row_delay[i_slot];
            if (i_ctl.win_ok) begin
                row_delay[i_slot] <= i_elem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_run   <= '0;
        end else if (i_en) begin
            r_valid <= i_valid;
            if (r_valid && r_ctl.win_ok) begin
                r_run <= o_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_ctl   <= i_ctl;
            r_col   <= i_col;
            r_hslot <= i_hslot;
            r_elem  <= i_elem;
        end
    end

    always_comb begin
        run_base = r_ctl.c_first ? '0 : r_run;
        run_drop = r_ctl.c_sub ? RUN_W'(r_old) : '0;
        o_run    = run_base + RUN_W'(r_elem) - run_drop;
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_col   = r_col;
    assign o_hslot = r_hslot;

endmodule

// ===== sv/max_window_sum_2d.sv =====
// ----------------------------------------------------------------------------
// max_window_sum_2d: largest fixed-size window sum over a raster matrix
// result path: row sum (stage b), column sum (stage c), maximum (stage d), output register
// throughput: one element per cycle; the input stalls only while a finished
//   result waits on the master side and the next frame's result is due
// reset: synchronous, active low; clears control, counters and sums; the
//   memories are not cleared, no clearing pass (row 0 reads column sums as 0)
// ----------------------------------------------------------------------------
module max_window_sum_2d #(
    parameter int MAX_COLS     = mws2d_pkg::DEF_MAX_COLS,
    parameter int MAX_WIN_ROWS = mws2d_pkg::DEF_MAX_WIN_ROWS,
    parameter int MAX_WIN_COLS = mws2d_pkg::DEF_MAX_WIN_COLS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [mws2d_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mws2d_pkg::CFG_W-1:0]          i_cfg_data,
    // slave side
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [mws2d_pkg::ELEM_W-1:0]         i_s_tdata,   // [15:0] elem_value
    // master side
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [mws2d_pkg::OUT_DATA_W-1:0]     o_m_tdata    // [26:0] best_sum
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CSL_W  = (MAX_WIN_COLS > 1) ? $clog2(MAX_WIN_COLS) : 1;
    localparam int RSL_W  = (MAX_WIN_ROWS > 1) ? $clog2(MAX_WIN_ROWS) : 1;
    localparam int HDEPTH = MAX_WIN_ROWS * MAX_COLS;
    localparam int HA_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int RUN_W  = mws2d_pkg::ELEM_W + $clog2(MAX_WIN_COLS);
    localparam int ACC_W  = RUN_W + $clog2(MAX_WIN_ROWS);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [mws2d_pkg::ROWS_W-1:0] r_row_count;
    logic [mws2d_pkg::COLS_W-1:0] r_col_count;
    logic [mws2d_pkg::WIN_W-1:0]  r_win_height;
    logic [mws2d_pkg::WIN_W-1:0]  r_win_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= mws2d_pkg::ROWS_W'(1);
            r_col_count  <= mws2d_pkg::COLS_W'(1);
            r_win_height <= mws2d_pkg::WIN_W'(1);
            r_win_width  <= mws2d_pkg::WIN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mws2d_pkg::CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[mws2d_pkg::ROWS_W-1:0];
                mws2d_pkg::CFG_COL_COUNT:  r_col_count  <= i_cfg_data[mws2d_pkg::COLS_W-1:0];
                mws2d_pkg::CFG_WIN_HEIGHT: r_win_height <= i_cfg_data[mws2d_pkg::WIN_W-1:0];
                mws2d_pkg::CFG_WIN_WIDTH:  r_win_width  <= i_cfg_data[mws2d_pkg::WIN_W-1:0];
            endcase
        end
    end

    // effective sizes: zero counts as one, columns saturate at capacity
    int eff_rows;
    int eff_cols;
    int eff_hgt;
    int eff_wid;

    always_comb begin
        eff_rows = (r_row_count == '0) ? 1 : int'(r_row_count);
        eff_cols = (r_col_count == '0) ? 1 : int'(r_col_count);
        if (eff_cols > MAX_COLS) begin
            eff_cols = MAX_COLS;
        end
        eff_hgt  = (r_win_height == '0) ? 1 : int'(r_win_height);
        eff_wid  = (r_win_width == '0) ? 1 : int'(r_win_width);
    end

    // ------------------------------------------------------------------
    // pipeline enable: everything freezes only when a result is due while
    // the output register still holds an untaken one
    // ------------------------------------------------------------------
    logic            en;
    logic            acc;
    logic            r_d_valid;
    mws2d_pkg::t_ctl r_d_ctl;
    logic            r_out_valid;

    assign en         = !(r_d_valid && r_d_ctl.last && r_out_valid && !i_m_tready);
    assign o_s_tready = en;
    assign acc        = i_s_tvalid && en;

    // ------------------------------------------------------------------
    // raster position and ring slots
    // ------------------------------------------------------------------
    logic [mws2d_pkg::ROWS_W-1:0] r_row;
    logic [COL_W-1:0]             r_col;
    logic [CSL_W-1:0]             r_cslot;
    logic [RSL_W-1:0]             r_rslot;
    logic                         col_end;
    logic                         frame_end;
    mws2d_pkg::t_ctl              a_ctl;
    logic [HA_W-1:0]              a_hslot;

    always_comb begin
        col_end          = int'(r_col) + 1 >= eff_cols;
        frame_end        = col_end && (int'(r_row) + 1 >= eff_rows);
        a_ctl.win_ok     = eff_hgt <= MAX_WIN_ROWS && eff_wid <= MAX_WIN_COLS
                           && eff_wid <= eff_cols && eff_hgt <= eff_rows;
        a_ctl.c_first    = r_col == '0;
        a_ctl.c_sub      = int'(r_col) >= eff_wid;
        a_ctl.c_full     = int'(r_col) + 1 >= eff_wid;
        a_ctl.r_sub      = int'(r_row) >= eff_hgt;
        a_ctl.r_full     = int'(r_row) + 1 >= eff_hgt;
        a_ctl.r_zero     = r_row == '0;
        a_ctl.last       = frame_end;
        // history entry: row slot times row stride plus column
        a_hslot          = HA_W'(HA_W'(r_rslot) * HA_W'(MAX_COLS)) + HA_W'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_cslot <= '0;
            r_rslot <= '0;
        end else if (acc) begin
            if (col_end) begin
                r_col   <= '0;
                r_cslot <= '0;
                if (frame_end) begin
                    r_row   <= '0;
                    r_rslot <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                    if (int'(r_rslot) + 1 >= eff_hgt || int'(r_rslot) + 1 >= MAX_WIN_ROWS) begin
                        r_rslot <= '0;
                    end else begin
                        r_rslot <= r_rslot + 1'b1;
                    end
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (int'(r_cslot) + 1 >= eff_wid || int'(r_cslot) + 1 >= MAX_WIN_COLS) begin
                    r_cslot <= '0;
                end else begin
                    r_cslot <= r_cslot + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage b: horizontal window sum
    // ------------------------------------------------------------------
    logic                    b_valid;
    mws2d_pkg::t_ctl         b_ctl;
    logic [COL_W-1:0]        b_col;
    logic [HA_W-1:0]         b_hslot;
    logic signed [RUN_W-1:0] b_run;

    mws2d_rowsum #(
        .MAX_COLS     (MAX_COLS),
        .MAX_WIN_ROWS (MAX_WIN_ROWS),
        .MAX_WIN_COLS (MAX_WIN_COLS)
    ) u_rowsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (acc),
        .i_elem  (signed'(i_s_tdata)),
        .i_slot  (r_cslot),
        .i_ctl   (a_ctl),
        .i_col   (r_col),
        .i_hslot (a_hslot),
        .o_valid (b_valid),
        .o_ctl   (b_ctl),
        .o_col   (b_col),
        .o_hslot (b_hslot),
        .o_run   (b_run)
    );

    // ------------------------------------------------------------------
    // stage c: vertical sum, read-modify-write of column sums and history
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] col_accum    [MAX_COLS];
    logic signed [RUN_W-1:0] hsum_history [HDEPTH];

    logic                    r_c_valid;
    mws2d_pkg::t_ctl         r_c_ctl;
    logic [COL_W-1:0]        r_c_col;
    logic [HA_W-1:0]         r_c_hslot;
    logic signed [RUN_W-1:0] r_c_run;
    logic signed [ACC_W-1:0] r_ca_rd;
    logic signed [RUN_W-1:0] r_hs_rd;
    // bypass of the write that lands on the same edge as the read
    logic                    r_fca_hit;
    logic signed [ACC_W-1:0] r_fca_val;
    logic                    r_fh_hit;
    logic signed [RUN_W-1:0] r_fh_val;

    logic                    c_write;
    logic signed [ACC_W-1:0] c_ca;
    logic signed [RUN_W-1:0] c_hs;
    logic signed [ACC_W-1:0] c_sum;

    always_comb begin
        c_write = r_c_valid && r_c_ctl.win_ok && r_c_ctl.c_full;
        c_ca    = r_fca_hit ? r_fca_val : r_ca_rd;
        c_hs    = r_fh_hit ? r_fh_val : r_hs_rd;
        c_sum   = (r_c_ctl.r_zero ? '0 : c_ca) + ACC_W'(r_c_run)
                  - (r_c_ctl.r_sub ? ACC_W'(c_hs) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (b_valid) begin
                r_ca_rd <= col_accum[b_col];
                r_hs_rd <= hsum_history[b_hslot];
            end
            if (c_write) begin
                col_accum[r_c_col]      <= c_sum;
                hsum_history[r_c_hslot] <= r_c_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_fca_hit <= 1'b0;
            r_fh_hit  <= 1'b0;
        end else if (en) begin
            r_c_valid <= b_valid;
            r_fca_hit <= c_write && b_valid && (r_c_col == b_col);
            r_fh_hit  <= c_write && b_valid && (r_c_hslot == b_hslot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fca_val <= c_sum;
            r_fh_val  <= r_c_run;
            if (b_valid) begin
                r_c_ctl   <= b_ctl;
                r_c_col   <= b_col;
                r_c_hslot <= b_hslot;
                r_c_run   <= b_run;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage d: running maximum and result
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0]       r_d_sum;
    logic signed [ACC_W-1:0]       r_best;
    logic signed [ACC_W-1:0]       d_cand;
    logic [mws2d_pkg::BEST_W-1:0]  r_out_data;

    always_comb begin
        d_cand = r_best;
        if (r_d_ctl.win_ok && r_d_ctl.c_full && r_d_ctl.r_full && r_d_sum > r_best) begin
            d_cand = r_d_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_c_valid) begin
            r_d_ctl <= r_c_ctl;
            r_d_sum <= c_sum;
        end
    end

    // best value restarts at zero after every frame; a new result may load
    // on the same edge the old one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (en && r_d_valid && r_d_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (en && r_d_valid) begin
                r_best <= r_d_ctl.last ? '0 : d_cand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_d_valid && r_d_ctl.last) begin
            r_out_data <= mws2d_pkg::BEST_W'(d_cand);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = mws2d_pkg::OUT_DATA_W'(r_out_data);

`ifndef SYNTHESIS
    // the input side only waits on a full output register that is not taken
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a pending result");

    // the running maximum never drops below zero
    a_best_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_best[ACC_W-1])
        else $error("best sum went negative");

    // the last beat of a frame returns the raster position to the origin
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && frame_end) |=> (r_row == '0 && r_col == '0 && r_rslot == '0))
        else $error("raster position not cleared at frame end");

    // a frame end leaving the last stage always presents a result
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_d_valid && r_d_ctl.last) |=> (o_m_tvalid && r_best == '0))
        else $error("frame end without result");
`endif

endmodule
